>>> design/qbe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qbe_pkg
// Shared types and character constants for the quoted byte escaper.
// ----------------------------------------------------------------------------
package qbe_pkg;

	typedef enum logic [1:0] {
		OP_BEGIN = 2'd0,
		OP_DATA  = 2'd1,
		OP_END   = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_ACTIVE = 2'd1,
		PH_TRUNC  = 2'd2
	} phase_t;

	localparam int          BUDGET_W     = 16;
	localparam int          MAX_RES      = 4;
	localparam int          CNT_W        = 3;
	localparam logic [15:0] BUDGET_RESET = 16'd256;
	// quotes, three dots and the terminator
	localparam logic [15:0] OVERHEAD     = 16'd6;

	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_LOW_N  = 8'h6E;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_PR_LO  = 8'h20;
	localparam logic [7:0] CH_PR_HI  = 8'h7E;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
		logic       err;
	} res_t;

	typedef struct packed {
		phase_t              phase;
		logic [BUDGET_W-1:0] space_left;
	} state_t;

endpackage

>>> design/quoted_byte_escaper_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quoted_byte_escaper_unit
// Turns a byte buffer into a quoted, C-escaped character stream in a budget.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats on s_*: s_tuser carries the op (begin, data, end), s_tdata
//   the raw byte. Output beats on m_*: one character per beat in m_tdata,
//   m_tlast on the closing character of a buffer (or on an error beat),
//   m_tuser set on the error beat that a begin with too small a budget gives.
//   cfg_we/cfg_wdata write the character budget; write only while idle.
// Path: an accepted beat waits in the input register until the result
//   register is free, is escaped into the result register, and its first
//   character shows on m_* straight from that register.
// Throughput: an item holds the result register until its 0 to 4 characters
//   have left one per beat through the output port; items that give no
//   characters pass at one per cycle. The result register refills at the
//   edge its last character leaves, so while m_tready stays high a stream
//   of bytes needing one character each flows at one beat per cycle.
// Reset: clears the valid flags, sets the phase idle, space to zero and the
//   budget to 256.
// Stall: with m_tready low the current character holds, the result register
//   keeps the rest, and one more input beat is held before s_tready drops.
// ----------------------------------------------------------------------------
module quoted_byte_escaper_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic [1:0]  s_tuser,   // [1:0] op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] out_char
	output logic        m_tlast,
	output logic        m_tuser,   // [0] error
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);

	// input register
	logic                 valid_s1;
	qbe_pkg::op_t         op_s1;
	logic [7:0]           byte_s1;

	// configuration and buffer state
	logic [qbe_pkg::BUDGET_W-1:0] budget_q;
	qbe_pkg::state_t              state_q;

	qbe_pkg::state_t                      nxt_state;
	logic [qbe_pkg::CNT_W-1:0]            esc_cnt;
	qbe_pkg::res_t [qbe_pkg::MAX_RES-1:0] esc_res;
	qbe_pkg::res_t                        head;
	logic                                 buf_free;
	logic                                 take;
	logic                                 s_acc;

	// item in the input register moves on once the result register is free
	assign take     = valid_s1 && buf_free;
	assign s_tready = !valid_s1 || take;
	assign s_acc    = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_acc) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			op_s1   <= qbe_pkg::op_t'(s_tuser);
			byte_s1 <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			budget_q <= qbe_pkg::BUDGET_RESET;
		end else if (cfg_we) begin
			budget_q <= cfg_wdata;
		end
	end

	// phase and remaining space advance as each item is escaped, in order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{phase: qbe_pkg::PH_IDLE, space_left: '0};
		end else if (take) begin
			state_q <= nxt_state;
		end
	end

	qbe_escape u_escape (
		.op        (op_s1),
		.data_byte (byte_s1),
		.budget    (budget_q),
		.cur       (state_q),
		.nxt       (nxt_state),
		.cnt       (esc_cnt),
		.res       (esc_res)
	);

	qbe_outbuf u_outbuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (take),
		.load_cnt (esc_cnt),
		.load_res (esc_res),
		.pop      (m_tready),
		.valid    (m_tvalid),
		.head     (head),
		.free     (buf_free)
	);

	assign m_tdata = head.ch;
	assign m_tlast = head.last;
	assign m_tuser = head.err;

endmodule

>>> design/qbe_escape.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qbe_escape
// Combinational escape of one item: result characters and next state.
// ----------------------------------------------------------------------------
module qbe_escape (
	input  qbe_pkg::op_t                            op,
	input  logic [7:0]                              data_byte,
	input  logic [qbe_pkg::BUDGET_W-1:0]            budget,
	input  qbe_pkg::state_t                         cur,
	output qbe_pkg::state_t                         nxt,
	output logic [qbe_pkg::CNT_W-1:0]               cnt,
	output qbe_pkg::res_t [qbe_pkg::MAX_RES-1:0]    res
);

	logic [qbe_pkg::CNT_W-1:0] need;

	// characters a data byte costs
	always_comb begin
		if (data_byte == qbe_pkg::CH_QUOTE || data_byte == qbe_pkg::CH_BSLASH ||
		    data_byte == qbe_pkg::CH_NL) begin
			need = 3'd2;
		end else if ((data_byte inside {[qbe_pkg::CH_PR_LO:qbe_pkg::CH_PR_HI]}) ||
		             data_byte == qbe_pkg::CH_TAB) begin
			need = 3'd1;
		end else begin
			need = 3'd4;
		end
	end

	always_comb begin
		nxt = cur;
		cnt = '0;
		res = '0;
		case (op)
			qbe_pkg::OP_BEGIN: begin
				cnt = 3'd1;
				if (budget < qbe_pkg::OVERHEAD) begin
					nxt.phase      = qbe_pkg::PH_IDLE;
					nxt.space_left = '0;
					res[0]         = '{ch: 8'h00, last: 1'b1, err: 1'b1};
				end else begin
					nxt.phase      = qbe_pkg::PH_ACTIVE;
					nxt.space_left = budget - qbe_pkg::OVERHEAD;
					res[0]         = '{ch: qbe_pkg::CH_QUOTE, last: 1'b0, err: 1'b0};
				end
			end
			qbe_pkg::OP_DATA: begin
				if (cur.phase == qbe_pkg::PH_ACTIVE) begin
					if (cur.space_left < {13'd0, need}) begin
						// no room: close with quote and dots
						cnt       = 3'd4;
						nxt.phase = qbe_pkg::PH_TRUNC;
						res[0]    = '{ch: qbe_pkg::CH_QUOTE, last: 1'b0, err: 1'b0};
						res[1]    = '{ch: qbe_pkg::CH_DOT, last: 1'b0, err: 1'b0};
						res[2]    = '{ch: qbe_pkg::CH_DOT, last: 1'b0, err: 1'b0};
						res[3]    = '{ch: qbe_pkg::CH_DOT, last: 1'b1, err: 1'b0};
					end else begin
						cnt            = need;
						nxt.space_left = cur.space_left - {13'd0, need};
						if (need == 3'd1) begin
							res[0] = '{ch: data_byte, last: 1'b0, err: 1'b0};
						end else if (need == 3'd2) begin
							res[0] = '{ch: qbe_pkg::CH_BSLASH, last: 1'b0, err: 1'b0};
							res[1] = '{ch: (data_byte == qbe_pkg::CH_NL) ?
							               qbe_pkg::CH_LOW_N : data_byte,
							           last: 1'b0, err: 1'b0};
						end else begin
							res[0] = '{ch: qbe_pkg::CH_BSLASH, last: 1'b0, err: 1'b0};
							res[1] = '{ch: qbe_pkg::CH_ZERO + {6'd0, data_byte[7:6]},
							           last: 1'b0, err: 1'b0};
							res[2] = '{ch: qbe_pkg::CH_ZERO + {5'd0, data_byte[5:3]},
							           last: 1'b0, err: 1'b0};
							res[3] = '{ch: qbe_pkg::CH_ZERO + {5'd0, data_byte[2:0]},
							           last: 1'b0, err: 1'b0};
						end
					end
				end
			end
			qbe_pkg::OP_END: begin
				nxt.phase = qbe_pkg::PH_IDLE;
				if (cur.phase == qbe_pkg::PH_ACTIVE) begin
					cnt    = 3'd1;
					res[0] = '{ch: qbe_pkg::CH_QUOTE, last: 1'b1, err: 1'b0};
				end
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

endmodule

>>> design/qbe_outbuf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qbe_outbuf
// Result register: holds up to four characters and shifts them out one a beat.
// ----------------------------------------------------------------------------
module qbe_outbuf (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    load,
	input  logic [qbe_pkg::CNT_W-1:0]               load_cnt,
	input  qbe_pkg::res_t [qbe_pkg::MAX_RES-1:0]    load_res,
	input  logic                                    pop,
	output logic                                    valid,
	output qbe_pkg::res_t                           head,
	output logic                                    free
);

	qbe_pkg::res_t [qbe_pkg::MAX_RES-1:0] ent_q;
	logic [qbe_pkg::CNT_W-1:0]            cnt_q;

	assign valid = (cnt_q != '0);
	assign head  = ent_q[0];
	// free when empty or when the final entry leaves this cycle
	assign free  = (cnt_q == '0) || (cnt_q == 3'd1 && pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= load_cnt;
		end else if (pop && valid) begin
			cnt_q <= cnt_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ent_q <= load_res;
		end else if (pop && valid) begin
			ent_q <= {qbe_pkg::res_t'('0), ent_q[qbe_pkg::MAX_RES-1:1]};
		end
	end

endmodule

>>> design/qbe_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qbe_checker
// Port-level checks for the quoted byte escaper, bound to the top level.
// ----------------------------------------------------------------------------
module qbe_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tlast,
	input logic       m_tuser
);

	// stalled output beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast) &&
		$stable(m_tuser))
		else $error("output beat changed under stall");

	// error beat is a lone zero character ending the text
	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast && m_tdata == 8'h00)
		else $error("malformed error beat");

	// a text ends on a closing quote or on the final dot
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast && !m_tuser |-> m_tdata == qbe_pkg::CH_QUOTE ||
		m_tdata == qbe_pkg::CH_DOT)
		else $error("text ends on an unexpected character");

	// input backpressure only while output is pending
	a_bp: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with no output pending");

endmodule

bind quoted_byte_escaper_unit qbe_checker u_qbe_checker (.*);

>>> sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the quoted byte escaper.
// A queue of pending beats feeds a falling-edge driver. A rising-edge monitor
// predicts the escaped characters of every accepted beat and checks each
// output beat against the oldest expected character. Phases vary the budget,
// the sender gaps and the receiver stalls, and one long receiver hold-off
// backs the block up.
// ----------------------------------------------------------------------------
module testbench;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE      = 8;

	typedef struct {
		qbe_pkg::op_t op;
		logic [7:0]   data;
	} byte_beat_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata   = 8'h00;
	logic [1:0]  s_tuser   = qbe_pkg::OP_NONE;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [7:0]  m_tdata;
	logic        m_tlast;
	logic        m_tuser;
	logic        cfg_we    = 1'b0;
	logic [15:0] cfg_wdata = 16'd0;

	byte_beat_t    pending_beats[$];
	byte_beat_t    next_beat;
	qbe_pkg::res_t expected_text[$];
	qbe_pkg::res_t want_char;
	logic          beat_taken = 1'b0;

	// escaper state as predicted
	logic [15:0]      text_budget = qbe_pkg::BUDGET_RESET;
	logic [15:0]      room_left   = 16'd0;
	qbe_pkg::phase_t  buf_phase   = qbe_pkg::PH_IDLE;

	int idle_pct      = 0;
	int stall_pct     = 0;
	int hold_requests = 0;
	int hold_seen     = 0;
	int hold_left     = 0;
	int mismatch_count = 0;
	int cycle_count    = 0;

	quoted_byte_escaper_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic void push_char(logic [7:0] c, logic l, logic e);
		qbe_pkg::res_t r;
		r.ch   = c;
		r.last = l;
		r.err  = e;
		expected_text.push_back(r);
	endfunction

	// characters one accepted beat produces, and the state it leaves
	function automatic void predict_escape(qbe_pkg::op_t op, logic [7:0] b);
		int need;
		case (op)
			qbe_pkg::OP_BEGIN: begin
				if (text_budget < qbe_pkg::OVERHEAD) begin
					buf_phase = qbe_pkg::PH_IDLE;
					room_left = 16'd0;
					push_char(8'h00, 1'b1, 1'b1);
				end else begin
					room_left = text_budget - qbe_pkg::OVERHEAD;
					buf_phase = qbe_pkg::PH_ACTIVE;
					push_char(qbe_pkg::CH_QUOTE, 1'b0, 1'b0);
				end
			end
			qbe_pkg::OP_DATA: begin
				if (buf_phase == qbe_pkg::PH_ACTIVE) begin
					if (b == qbe_pkg::CH_QUOTE || b == qbe_pkg::CH_BSLASH ||
					    b == qbe_pkg::CH_NL)
						need = 2;
					else if ((b >= qbe_pkg::CH_PR_LO && b <= qbe_pkg::CH_PR_HI) ||
					         b == qbe_pkg::CH_TAB)
						need = 1;
					else
						need = 4;
					if (room_left < need) begin
						// no room: close with quote and dots, drop the rest
						push_char(qbe_pkg::CH_QUOTE, 1'b0, 1'b0);
						push_char(qbe_pkg::CH_DOT, 1'b0, 1'b0);
						push_char(qbe_pkg::CH_DOT, 1'b0, 1'b0);
						push_char(qbe_pkg::CH_DOT, 1'b1, 1'b0);
						buf_phase = qbe_pkg::PH_TRUNC;
					end else begin
						room_left = room_left - 16'(need);
						if (need == 1) begin
							push_char(b, 1'b0, 1'b0);
						end else if (need == 2) begin
							push_char(qbe_pkg::CH_BSLASH, 1'b0, 1'b0);
							push_char((b == qbe_pkg::CH_NL) ? qbe_pkg::CH_LOW_N : b,
								1'b0, 1'b0);
						end else begin
							push_char(qbe_pkg::CH_BSLASH, 1'b0, 1'b0);
							push_char(qbe_pkg::CH_ZERO + {6'd0, b[7:6]}, 1'b0, 1'b0);
							push_char(qbe_pkg::CH_ZERO + {5'd0, b[5:3]}, 1'b0, 1'b0);
							push_char(qbe_pkg::CH_ZERO + {5'd0, b[2:0]}, 1'b0, 1'b0);
						end
					end
				end
			end
			qbe_pkg::OP_END: begin
				if (buf_phase == qbe_pkg::PH_ACTIVE)
					push_char(qbe_pkg::CH_QUOTE, 1'b1, 1'b0);
				buf_phase = qbe_pkg::PH_IDLE;
			end
			default: ;
		endcase
	endfunction

	// sender: next beat goes out once the current one is taken
	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || beat_taken) begin
			if (pending_beats.size() > 0 && $urandom_range(99) >= idle_pct) begin
				next_beat = pending_beats.pop_front();
				s_tvalid <= 1'b1;
				s_tuser  <= next_beat.op;
				s_tdata  <= next_beat.data;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver: random stalls, plus a long hold-off on request
	always @(negedge clk) begin
		if (hold_requests != hold_seen) begin
			hold_seen = hold_requests;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// monitor: predict on input beats, check output beats
	always @(posedge clk) begin
		if (!arst_n) begin
			beat_taken <= 1'b0;
		end else begin
			beat_taken <= s_tvalid && s_tready;
			if (s_tvalid && s_tready)
				predict_escape(qbe_pkg::op_t'(s_tuser), s_tdata);
			if (m_tvalid && m_tready) begin
				if (expected_text.size() == 0) begin
					$display("%0t: unexpected beat ch=%h last=%b err=%b",
						$time, m_tdata, m_tlast, m_tuser);
					mismatch_count++;
				end else begin
					want_char = expected_text.pop_front();
					if (m_tdata !== want_char.ch || m_tlast !== want_char.last ||
					    m_tuser !== want_char.err) begin
						$display("%0t: expected ch=%h last=%b err=%b, got ch=%h last=%b err=%b",
							$time, want_char.ch, want_char.last, want_char.err,
							m_tdata, m_tlast, m_tuser);
						mismatch_count++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic offer(qbe_pkg::op_t op, logic [7:0] d);
		byte_beat_t bt;
		bt.op   = op;
		bt.data = d;
		pending_beats.push_back(bt);
	endtask

	function automatic logic [7:0] pick_byte();
		logic [7:0] odd_bytes [8] = '{qbe_pkg::CH_QUOTE, qbe_pkg::CH_BSLASH,
			qbe_pkg::CH_NL, qbe_pkg::CH_TAB, 8'h00, 8'hFF, 8'h7F, 8'h80};
		case ($urandom_range(3))
			0, 1: return 8'($urandom_range(255));
			2: return odd_bytes[$urandom_range(7)];
			default: return 8'($urandom_range(qbe_pkg::CH_PR_LO, qbe_pkg::CH_PR_HI));
		endcase
	endfunction

	// small budgets in half of the picks so that truncation and errors come up often
	function automatic logic [15:0] pick_budget();
		case ($urandom_range(5))
			0: return 16'($urandom_range(0, 5));
			1: return qbe_pkg::OVERHEAD;
			2: return 16'($urandom_range(7, 24));
			3: return 16'($urandom_range(25, 300));
			4: return 16'hFFFF;
			default: return qbe_pkg::BUDGET_RESET;
		endcase
	endfunction

	task automatic queue_buffer(int len, bit with_end);
		offer(qbe_pkg::OP_BEGIN, 8'($urandom_range(255)));
		for (int i = 0; i < len; i++)
			offer(qbe_pkg::OP_DATA, pick_byte());
		if (with_end)
			offer(qbe_pkg::OP_END, 8'($urandom_range(255)));
	endtask

	// nothing queued, nothing in flight, then let the pipe settle
	task automatic wait_until_idle();
		while (pending_beats.size() > 0 || s_tvalid || expected_text.size() > 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_budget(logic [15:0] v);
		@(negedge clk);
		cfg_we      <= 1'b1;
		cfg_wdata   <= v;
		text_budget = v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int send_gaps [4] = '{0, 82, 0, 35};
		int recv_gaps [4] = '{0, 0, 82, 35};
		int counted;
		int len;
		int roll;

		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		// directed, at the reset budget: ignored ops while idle, every
		// escape class, a stray op mid-buffer and a restart while open
		offer(qbe_pkg::OP_DATA, 8'h78);
		offer(qbe_pkg::OP_END, 8'h00);
		offer(qbe_pkg::OP_NONE, 8'hA5);
		offer(qbe_pkg::OP_BEGIN, 8'h00);
		offer(qbe_pkg::OP_DATA, 8'h00);
		offer(qbe_pkg::OP_DATA, 8'hFF);
		offer(qbe_pkg::OP_DATA, qbe_pkg::CH_QUOTE);
		offer(qbe_pkg::OP_DATA, qbe_pkg::CH_BSLASH);
		offer(qbe_pkg::OP_DATA, qbe_pkg::CH_NL);
		offer(qbe_pkg::OP_DATA, qbe_pkg::CH_TAB);
		offer(qbe_pkg::OP_DATA, qbe_pkg::CH_PR_LO);
		offer(qbe_pkg::OP_DATA, qbe_pkg::CH_PR_HI);
		offer(qbe_pkg::OP_DATA, 8'h7F);
		offer(qbe_pkg::OP_DATA, 8'h1F);
		offer(qbe_pkg::OP_DATA, 8'h80);
		offer(qbe_pkg::OP_NONE, 8'h5A);
		offer(qbe_pkg::OP_BEGIN, 8'hFF);
		offer(qbe_pkg::OP_DATA, 8'h41);
		offer(qbe_pkg::OP_END, 8'hFF);
		wait_until_idle();

		// zero budget: begin errors out, data afterward is ignored
		write_budget(16'd0);
		offer(qbe_pkg::OP_BEGIN, 8'h00);
		offer(qbe_pkg::OP_DATA, 8'h61);
		wait_until_idle();

		// budget of exactly the overhead: first byte truncates, end is silent
		write_budget(qbe_pkg::OVERHEAD);
		offer(qbe_pkg::OP_BEGIN, 8'h00);
		offer(qbe_pkg::OP_DATA, 8'h61);
		offer(qbe_pkg::OP_END, 8'h00);
		wait_until_idle();

		for (int p = 0; p < 4; p++) begin
			idle_pct  = send_gaps[p];
			stall_pct = recv_gaps[p];
			write_budget(pick_budget());
			counted = 0;
			while (counted < 12) begin
				if ($urandom_range(3) == 0) begin
					wait_until_idle();
					write_budget(pick_budget());
				end
				roll = $urandom_range(9);
				if (roll < 2) begin
					offer(qbe_pkg::op_t'($urandom_range(3)), 8'($urandom_range(255)));
				end else begin
					// roll 2 leaves the buffer open for the next begin to drop
					len = $urandom_range(0, 10);
					queue_buffer(len, roll != 2);
					counted += len + 2;
				end
			end
			wait_until_idle();
		end

		// receiver holds off while a long buffer keeps coming
		idle_pct  = 0;
		stall_pct = 0;
		write_budget(16'hFFFF);
		queue_buffer(20, 1'b1);
		hold_requests++;
		wait_until_idle();

		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
